### sv/slbm_pkg.sv
// ----------------------------------------------------------------------------
// slbm_pkg
// Shared types and constants for the serial loaded bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package slbm_pkg;

    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int MREG_W       = 5;
    localparam int POS_W        = 3;
    localparam int VARIANT_W    = 2;
    localparam int PRG_BANK_W   = 4;
    localparam int CHR_BANK_W   = 5;
    localparam int MIRROR_W     = 2;

    localparam int ACT_BIT      = 15;
    localparam int LOAD_RST_BIT = 7;
    localparam int SEL_LSB      = 13;
    localparam int LAST_POS     = 4;

    localparam logic [MREG_W-1:0] CTL_RESET_VAL = 5'h0C;
    localparam logic [MREG_W-1:0] CTL_SET_MASK  = 5'h0C;
    localparam logic [MREG_W-1:0] LOW4_MASK     = 5'h0F;
    localparam logic [MREG_W-1:0] LOW3_MASK     = 5'h07;
    localparam logic [MREG_W-1:0] BIT3_MASK     = 5'h08;
    localparam logic [MREG_W-1:0] EVEN_MASK     = 5'h1E;

    typedef enum logic [VARIANT_W-1:0] {
        VARIANT_OTHER = 2'd0,
        VARIANT_REV_A = 2'd1,
        VARIANT_REV_B = 2'd2,
        VARIANT_SPARE = 2'd3
    } variant_t;

    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_CHR0    = 2'd1,
        SEL_CHR1    = 2'd2,
        SEL_PRG     = 2'd3
    } reg_sel_t;

    typedef struct packed {
        logic [MREG_W-1:0] ctl;
        logic [MREG_W-1:0] chr0;
        logic [MREG_W-1:0] chr1;
        logic [MREG_W-1:0] prg;
    } mapper_regs_t;

    typedef struct packed {
        logic                  remapped;
        logic [PRG_BANK_W-1:0] prg_bank_low;
        logic [PRG_BANK_W-1:0] prg_bank_high;
        logic [CHR_BANK_W-1:0] chr_bank_low;
        logic [CHR_BANK_W-1:0] chr_bank_high;
        logic [MIRROR_W-1:0]   mirroring_mode;
        logic                  prg_ram_enable;
    } bank_map_t;

endpackage

`default_nettype wire

### sv/slbm_if.sv
// ----------------------------------------------------------------------------
// slbm_if
// Valid/ready channels for bus write words and bank map words.
// ----------------------------------------------------------------------------
`default_nettype none

interface slbm_bus_if;
    import slbm_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] cpu_address;
    logic [DATA_W-1:0] write_data;
    logic              double_write;

    modport source (output valid, output cpu_address, output write_data,
                    output double_write, input ready);
    modport sink   (input valid, input cpu_address, input write_data,
                    input double_write, output ready);
endinterface

interface slbm_map_if;
    import slbm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  remapped;
    logic [PRG_BANK_W-1:0] prg_bank_low;
    logic [PRG_BANK_W-1:0] prg_bank_high;
    logic [CHR_BANK_W-1:0] chr_bank_low;
    logic [CHR_BANK_W-1:0] chr_bank_high;
    logic [MIRROR_W-1:0]   mirroring_mode;
    logic                  prg_ram_enable;

    modport source (output valid, output remapped, output prg_bank_low,
                    output prg_bank_high, output chr_bank_low,
                    output chr_bank_high, output mirroring_mode,
                    output prg_ram_enable, input ready);
    modport sink   (input valid, input remapped, input prg_bank_low,
                    input prg_bank_high, input chr_bank_low,
                    input chr_bank_high, input mirroring_mode,
                    input prg_ram_enable, output ready);
endinterface

`default_nettype wire

### sv/slbm_loader.sv
// ----------------------------------------------------------------------------
// slbm_loader
// Serial shift loader and the four mapper registers.
// ----------------------------------------------------------------------------
`default_nettype none

module slbm_loader
    import slbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [ADDR_W-1:0] cpu_address,
    input  wire logic [DATA_W-1:0] write_data,
    input  wire logic              double_write,
    output mapper_regs_t           regs_next,
    output logic                   remap
);

    mapper_regs_t      regs_reg;
    logic [MREG_W-1:0] accum_reg, accum_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              just_reset_reg, just_reset_next;

    logic              act;
    logic [MREG_W-1:0] accum_shift;
    reg_sel_t          sel;

    assign sel = reg_sel_t'(cpu_address[SEL_LSB+1:SEL_LSB]);

    always_comb
    begin
        accum_shift = accum_reg;
        if (pos_reg <= POS_W'(LAST_POS))
        begin
            accum_shift = accum_reg
                | (MREG_W'(write_data[0]) << pos_reg[$clog2(MREG_W)-1:0]);
        end
    end

    always_comb
    begin
        regs_next       = regs_reg;
        accum_next      = accum_reg;
        pos_next        = pos_reg;
        just_reset_next = just_reset_reg;
        remap           = 1'b0;
        act             = cpu_address[ACT_BIT];
        if (act && just_reset_reg)
        begin
            just_reset_next = 1'b0;
            if (double_write)
            begin
                act = 1'b0;
            end
        end
        if (act)
        begin
            if (write_data[LOAD_RST_BIT])
            begin
                just_reset_next = 1'b1;
                accum_next      = '0;
                pos_next        = '0;
                regs_next.ctl   = regs_reg.ctl | CTL_SET_MASK;
            end
            else if (pos_reg >= POS_W'(LAST_POS))
            begin
                unique case (sel)
                    SEL_CONTROL: regs_next.ctl  = accum_shift;
                    SEL_CHR0:    regs_next.chr0 = accum_shift;
                    SEL_CHR1:    regs_next.chr1 = accum_shift;
                    SEL_PRG:     regs_next.prg  = accum_shift;
                    default:     regs_next      = regs_reg;
                endcase
                accum_next = '0;
                pos_next   = '0;
                remap      = 1'b1;
            end
            else
            begin
                accum_next = accum_shift;
                pos_next   = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ctl   <= CTL_RESET_VAL;
            regs_reg.chr0  <= '0;
            regs_reg.chr1  <= '0;
            regs_reg.prg   <= '0;
            accum_reg      <= '0;
            pos_reg        <= '0;
            just_reset_reg <= 1'b0;
        end
        else if (fire)
        begin
            regs_reg       <= regs_next;
            accum_reg      <= accum_next;
            pos_reg        <= pos_next;
            just_reset_reg <= just_reset_next;
        end
    end

endmodule

`default_nettype wire

### sv/slbm_bank_decode.sv
// ----------------------------------------------------------------------------
// slbm_bank_decode
// Program and pattern bank, mirroring and work RAM decode.
// ----------------------------------------------------------------------------
`default_nettype none

module slbm_bank_decode
    import slbm_pkg::*;
(
    input  wire mapper_regs_t regs,
    input  wire variant_t     variant,
    input  wire logic         remap,
    output bank_map_t         result
);

    logic [MREG_W-1:0] prg_lo, prg_hi;
    logic [MREG_W-1:0] prg_lo_fix, prg_hi_fix;
    logic              big_bank;

    always_comb
    begin
        priority if (regs.ctl[3] && regs.ctl[2])
        begin
            prg_lo = regs.prg;
            prg_hi = regs.prg | LOW4_MASK;
        end
        else if (regs.ctl[3])
        begin
            prg_lo = '0;
            prg_hi = regs.prg & LOW4_MASK;
        end
        else
        begin
            prg_lo = regs.prg & EVEN_MASK;
            prg_hi = (regs.prg & EVEN_MASK) | MREG_W'(1);
        end
    end

    // 256k half select on revision a
    assign big_bank   = regs.prg[4] && (variant == VARIANT_REV_A);
    assign prg_lo_fix = big_bank ? ((prg_lo & LOW3_MASK) | (regs.prg & BIT3_MASK)) : prg_lo;
    assign prg_hi_fix = big_bank ? ((prg_hi & LOW3_MASK) | (regs.prg & BIT3_MASK)) : prg_hi;

    always_comb
    begin
        result.remapped      = remap;
        result.prg_bank_low  = prg_lo_fix[PRG_BANK_W-1:0];
        result.prg_bank_high = prg_hi_fix[PRG_BANK_W-1:0];
        if (regs.ctl[4])
        begin
            result.chr_bank_low  = regs.chr0;
            result.chr_bank_high = regs.chr1;
        end
        else
        begin
            result.chr_bank_low  = regs.chr0 & EVEN_MASK;
            result.chr_bank_high = (regs.chr0 & EVEN_MASK) | CHR_BANK_W'(1);
        end
        result.mirroring_mode = regs.ctl[MIRROR_W-1:0];
        result.prg_ram_enable = !((variant == VARIANT_REV_B) && regs.prg[4]);
    end

endmodule

`default_nettype wire

### sv/serial_loaded_bank_mapper_unit.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_unit
// Serial loaded bank mapper: one bus write word in, one bank map word out.
// ----------------------------------------------------------------------------
//  channel     dir   handshake      word
//  bus_write   in    valid/ready    cpu_address, write_data, double_write
//  bank_map    out   valid/ready    remapped, banks, mirroring, ram enable
//  cfg_write   in    write enable   chip_variant
//
//  a word is taken every cycle unless a stalled output holds the input
//  register full; input register, then loader update into the result register
//  rst_n resets the loader and mapper registers (control to 5'h0C, others to 0)
//  and clears both valid flags; a stalled result holds in the result register;
//  the input register keeps taking a word while the result register can drain on the same edge
// ----------------------------------------------------------------------------
`default_nettype none

module serial_loaded_bank_mapper_unit
    import slbm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [VARIANT_W-1:0] cfg_write_data,
    slbm_bus_if.sink                  bus_write,
    slbm_map_if.source                bank_map
);

    variant_t          variant_reg;
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic              s1_dbl_reg;
    logic              out_valid_reg;
    bank_map_t         out_reg;

    logic              out_free;
    logic              s1_fire;
    logic              in_fire;
    mapper_regs_t      regs_next;
    logic              remap;
    bank_map_t         result_next;

    assign out_free        = !out_valid_reg || bank_map.ready;
    assign s1_fire         = s1_valid_reg && out_free;
    assign bus_write.ready = !s1_valid_reg || out_free;
    assign in_fire         = bus_write.valid && bus_write.ready;

    slbm_loader u_loader (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (s1_fire),
        .cpu_address  (s1_addr_reg),
        .write_data   (s1_data_reg),
        .double_write (s1_dbl_reg),
        .regs_next    (regs_next),
        .remap        (remap)
    );

    slbm_bank_decode u_decode (
        .regs    (regs_next),
        .variant (variant_reg),
        .remap   (remap),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg   <= VARIANT_OTHER;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                variant_reg <= variant_t'(cfg_write_data);
            end
            if (bus_write.ready)
            begin
                s1_valid_reg <= bus_write.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg <= bus_write.cpu_address;
            s1_data_reg <= bus_write.write_data;
            s1_dbl_reg  <= bus_write.double_write;
        end
        if (s1_fire)
        begin
            out_reg <= result_next;
        end
    end

    assign bank_map.valid          = out_valid_reg;
    assign bank_map.remapped       = out_reg.remapped;
    assign bank_map.prg_bank_low   = out_reg.prg_bank_low;
    assign bank_map.prg_bank_high  = out_reg.prg_bank_high;
    assign bank_map.chr_bank_low   = out_reg.chr_bank_low;
    assign bank_map.chr_bank_high  = out_reg.chr_bank_high;
    assign bank_map.mirroring_mode = out_reg.mirroring_mode;
    assign bank_map.prg_ram_enable = out_reg.prg_ram_enable;

endmodule

`default_nettype wire

### sv/slbm_checker.sv
// ----------------------------------------------------------------------------
// slbm_checker
// Port level checks for the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slbm_checker
    import slbm_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cfg_write_en,
    input wire logic [VARIANT_W-1:0] cfg_write_data,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire bank_map_t            out_word
);

    logic [VARIANT_W-1:0] variant_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            variant_reg <= cfg_write_data;
        end
    end

    // a draining output always frees the input side
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // work ram can only be disabled on revision b
    a_ram_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (variant_reg != VARIANT_REV_B)) |-> out_word.prg_ram_enable)
        else $error("work ram disabled outside revision b");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_word))
        else $error("result word changed while stalled");

endmodule

bind serial_loaded_bank_mapper_unit slbm_checker u_slbm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_ready       (bus_write.ready),
    .out_valid      (bank_map.valid),
    .out_ready      (bank_map.ready),
    .out_word       ({bank_map.remapped, bank_map.prg_bank_low, bank_map.prg_bank_high,
                      bank_map.chr_bank_low, bank_map.chr_bank_high,
                      bank_map.mirroring_mode, bank_map.prg_ram_enable})
);

`default_nettype wire
